// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define LRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer check failed");

`endif

// ===== rtl/lrc_pkg.sv =====
// Shared types and constants of the clipped line rasterizer.
package lrc_pkg;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // Configuration register indexes (byte address is 4 times the index).
    localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BYTES_PER_PIX  = 3'd2;
    localparam logic [2:0] REG_ROW_PITCH      = 3'd3;
    localparam logic [2:0] REG_BASE_ADDRESS   = 3'd4;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // Classification of one queued item.
    typedef struct packed {
        logic is_start;
        logic neg_x;
        logic neg_y;
        logic x_major;
        logic zero_len;
    } lrc_cmd_t;

    // Surface configuration as seen by the address stage.
    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [2:0]  bpp;
        logic [15:0] pitch;
        logic [31:0] base;
    } lrc_cfg_t;

endpackage

// ===== rtl/lrc_front.sv =====
// Front end: accepts items, classifies start items and queues them for the stepper.
module lrc_front
    import lrc_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic [31:0]                  line_color,
    output logic                         q_valid,
    input  logic                         q_pop,
    output lrc_cmd_t                     q_cmd,
    output logic signed [COORD_BITS-1:0] q_x0,
    output logic signed [COORD_BITS-1:0] q_y0,
    output logic signed [COORD_BITS-1:0] q_x1,
    output logic signed [COORD_BITS-1:0] q_y1,
    output logic [COORD_BITS:0]          q_adx,
    output logic [COORD_BITS:0]          q_ady,
    output logic [31:0]                  q_color
);

    localparam int DW       = COORD_BITS + 1;
    localparam int CMD_BITS = $bits(lrc_cmd_t);
    localparam int ENTRY_W  = 4 * COORD_BITS + 2 * DW + 32 + CMD_BITS;

    logic [ENTRY_W-1:0]   mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;

    logic               push;
    logic [DW-1:0]      dx, dy;
    logic [DW-1:0]      adx, ady;
    lrc_cmd_t           cmd;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;
    logic [CMD_BITS-1:0] rd_cmd_bits;

    assign in_stall = (count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);

    always_comb
    begin
        dx  = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
        dy  = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
        adx = dx[DW-1] ? (~dx + 1'b1) : dx;
        ady = dy[DW-1] ? (~dy + 1'b1) : dy;
        cmd.is_start = (func == FUNC_START);
        cmd.neg_x    = dx[DW-1];
        cmd.neg_y    = dy[DW-1];
        cmd.x_major  = (ady < adx);
        cmd.zero_len = (dx == '0) && (dy == '0);
        wr_entry = {line_color, start_x, start_y, end_x, end_y, adx, ady, cmd};
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + {{QPTR_BITS{1'b0}}, push} - {{QPTR_BITS{1'b0}}, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign rd_entry = mem_reg[rd_ptr_reg];
    assign {q_color, q_x0, q_y0, q_x1, q_y1, q_adx, q_ady, rd_cmd_bits} = rd_entry;
    assign q_cmd = lrc_cmd_t'(rd_cmd_bits);

endmodule

// ===== rtl/lrc_stepper.sv =====
// Back end stepper: runs the Bresenham state and registers one pixel per step.
module lrc_stepper
    import lrc_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  lrc_cmd_t                     q_cmd,
    input  logic signed [COORD_BITS-1:0] q_x0,
    input  logic signed [COORD_BITS-1:0] q_y0,
    input  logic signed [COORD_BITS-1:0] q_x1,
    input  logic signed [COORD_BITS-1:0] q_y1,
    input  logic [COORD_BITS:0]          q_adx,
    input  logic [COORD_BITS:0]          q_ady,
    input  logic [31:0]                  q_color,
    input  logic                         pix_ready,
    output logic                         pix_valid,
    output logic signed [COORD_BITS-1:0] pix_x,
    output logic signed [COORD_BITS-1:0] pix_y,
    output logic                         pix_last,
    output logic [31:0]                  pix_color
);

    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] tgt_x_reg, tgt_x_next;
    logic signed [COORD_BITS-1:0] tgt_y_reg, tgt_y_next;
    logic                         neg_x_reg, neg_x_next;
    logic                         neg_y_reg, neg_y_next;
    logic [DW-1:0]                adx_reg, adx_next;
    logic [DW-1:0]                ady_reg, ady_next;
    logic                         x_major_reg, x_major_next;
    logic signed [EW-1:0]         err_reg, err_next;
    logic [31:0]                  color_reg, color_next;
    logic                         active_reg, active_next;
    logic                         valid_reg, valid_next;
    logic                         last_reg, last_next;

    logic                         stage_ok;
    logic [DW-1:0]                major, minor;
    logic signed [EW-1:0]         err_add, err_sub;
    logic                         minor_step;
    logic signed [COORD_BITS-1:0] step_x, step_y;
    logic signed [COORD_BITS-1:0] nx, ny;
    logic                         at_end;

    assign stage_ok = !valid_reg || pix_ready;
    assign q_pop    = q_valid && stage_ok;

    // One Bresenham step from the current state.
    always_comb
    begin
        major   = x_major_reg ? adx_reg : ady_reg;
        minor   = x_major_reg ? ady_reg : adx_reg;
        err_add = err_reg + $signed({1'b0, minor, 1'b0});
        minor_step = (err_add > $signed({2'b00, major}));
        err_sub = err_add - $signed({1'b0, major, 1'b0});
        step_x  = neg_x_reg ? '1 : COORD_BITS'(1);
        step_y  = neg_y_reg ? '1 : COORD_BITS'(1);
        if (x_major_reg)
        begin
            nx = cur_x_reg + step_x;
            ny = minor_step ? (cur_y_reg + step_y) : cur_y_reg;
        end
        else
        begin
            ny = cur_y_reg + step_y;
            nx = minor_step ? (cur_x_reg + step_x) : cur_x_reg;
        end
        at_end = x_major_reg ? (nx == tgt_x_reg) : (ny == tgt_y_reg);
    end

    always_comb
    begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        tgt_x_next   = tgt_x_reg;
        tgt_y_next   = tgt_y_reg;
        neg_x_next   = neg_x_reg;
        neg_y_next   = neg_y_reg;
        adx_next     = adx_reg;
        ady_next     = ady_reg;
        x_major_next = x_major_reg;
        err_next     = err_reg;
        color_next   = color_reg;
        active_next  = active_reg;
        last_next    = last_reg;
        valid_next   = stage_ok ? 1'b0 : valid_reg;
        if (q_pop)
        begin
            if (q_cmd.is_start)
            begin
                // A start drops any running line.
                cur_x_next   = q_x0;
                cur_y_next   = q_y0;
                tgt_x_next   = q_x1;
                tgt_y_next   = q_y1;
                neg_x_next   = q_cmd.neg_x;
                neg_y_next   = q_cmd.neg_y;
                adx_next     = q_adx;
                ady_next     = q_ady;
                x_major_next = q_cmd.x_major;
                err_next     = '0;
                color_next   = q_color;
                active_next  = !q_cmd.zero_len;
                last_next    = q_cmd.zero_len;
                valid_next   = 1'b1;
            end
            else if (active_reg)
            begin
                cur_x_next  = nx;
                cur_y_next  = ny;
                err_next    = minor_step ? err_sub : err_add;
                active_next = !at_end;
                last_next   = at_end;
                valid_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            tgt_x_reg   <= '0;
            tgt_y_reg   <= '0;
            neg_x_reg   <= 1'b0;
            neg_y_reg   <= 1'b0;
            adx_reg     <= '0;
            ady_reg     <= '0;
            x_major_reg <= 1'b0;
            err_reg     <= '0;
            color_reg   <= '0;
            active_reg  <= 1'b0;
            valid_reg   <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            tgt_x_reg   <= tgt_x_next;
            tgt_y_reg   <= tgt_y_next;
            neg_x_reg   <= neg_x_next;
            neg_y_reg   <= neg_y_next;
            adx_reg     <= adx_next;
            ady_reg     <= ady_next;
            x_major_reg <= x_major_next;
            err_reg     <= err_next;
            color_reg   <= color_next;
            active_reg  <= active_next;
            valid_reg   <= valid_next;
            last_reg    <= last_next;
        end
    end

    assign pix_valid = valid_reg;
    assign pix_x     = cur_x_reg;
    assign pix_y     = cur_y_reg;
    assign pix_last  = last_reg;
    assign pix_color = color_reg;

endmodule

// ===== rtl/lrc_pixel.sv =====
// Back end pixel stage: clip test, address multiply and the output register.
module lrc_pixel
    import lrc_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lrc_cfg_t                     cfg,
    input  logic                         pix_valid,
    output logic                         pix_ready,
    input  logic signed [COORD_BITS-1:0] pix_x,
    input  logic signed [COORD_BITS-1:0] pix_y,
    input  logic                         pix_last,
    input  logic [31:0]                  pix_color,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         visible,
    output logic [31:0]                  write_address,
    output logic [31:0]                  pixel_value,
    output logic                         last
);

    localparam int CWV = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;

    logic                         m_valid_reg, m_valid_next;
    logic signed [COORD_BITS-1:0] m_x_reg, m_y_reg;
    logic                         m_vis_reg, m_last_reg;
    logic [31:0]                  m_px_reg, m_py_reg, m_color_reg;

    logic                         o_valid_reg, o_valid_next;
    logic signed [COORD_BITS-1:0] o_x_reg, o_y_reg;
    logic                         o_vis_reg, o_last_reg;
    logic [31:0]                  o_addr_reg, o_color_reg;

    logic        out_ok, m_ok;
    logic [CWV-1:0] xp1, yp1;
    logic        vis;
    logic [31:0] xs, ys;

    assign out_ok    = !o_valid_reg || !out_stall;
    assign m_ok      = !m_valid_reg || out_ok;
    assign pix_ready = m_ok;

    // x < width-1 with x non-negative is the same as x+1 < width.
    always_comb
    begin
        xp1 = CWV'(pix_x[COORD_BITS-2:0]) + 1'b1;
        yp1 = CWV'(pix_y[COORD_BITS-2:0]) + 1'b1;
        vis = !pix_x[COORD_BITS-1] && !pix_y[COORD_BITS-1]
              && (xp1 < CWV'(cfg.width)) && (yp1 < CWV'(cfg.height));
        xs  = 32'(pix_x);
        ys  = 32'(pix_y);
    end

    assign m_valid_next = m_ok ? pix_valid : m_valid_reg;
    assign o_valid_next = out_ok ? m_valid_reg : o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_ok && pix_valid)
        begin
            m_x_reg     <= pix_x;
            m_y_reg     <= pix_y;
            m_vis_reg   <= vis;
            m_last_reg  <= pix_last;
            m_color_reg <= pix_color;
            m_px_reg    <= xs * {29'd0, cfg.bpp};
            m_py_reg    <= ys * {16'd0, cfg.pitch};
        end
        if (out_ok && m_valid_reg)
        begin
            o_x_reg     <= m_x_reg;
            o_y_reg     <= m_y_reg;
            o_vis_reg   <= m_vis_reg;
            o_last_reg  <= m_last_reg;
            o_color_reg <= m_color_reg;
            o_addr_reg  <= cfg.base + m_px_reg + m_py_reg;
        end
    end

    assign out_valid     = o_valid_reg;
    assign pixel_x       = o_x_reg;
    assign pixel_y       = o_y_reg;
    assign visible       = o_vis_reg;
    assign write_address = o_addr_reg;
    assign pixel_value   = o_color_reg;
    assign last          = o_last_reg;

endmodule

// ===== rtl/line_rasterizer_clipped_top.sv =====
// Top level of the clipped line rasterizer: configuration registers and the pipeline.
// Throughput: one item per cycle while in_stall is low; every start and every advance
// of a running line gives one pixel, an advance while idle gives none.
// Path: an accepted item is queued, then registered by the stepper, multiply and output
// registers before out_valid rises; stalls can hold it longer.
// Reset: rst_n clears the queue, stepper state and valid flags and loads register defaults.
module line_rasterizer_clipped_top
    import lrc_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic [31:0]                  line_color,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         visible,
    output logic [31:0]                  write_address,
    output logic [31:0]                  pixel_value,
    output logic                         last
);

    lrc_cfg_t cfg_reg, cfg_next;
    logic     cfg_write;
    logic [2:0] reg_idx;

    lrc_cmd_t                     q_cmd;
    logic                         q_valid, q_pop;
    logic signed [COORD_BITS-1:0] q_x0, q_y0, q_x1, q_y1;
    logic [COORD_BITS:0]          q_adx, q_ady;
    logic [31:0]                  q_color;

    logic                         pix_valid, pix_ready, pix_last;
    logic signed [COORD_BITS-1:0] pix_x, pix_y;
    logic [31:0]                  pix_color;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_SURFACE_WIDTH:  cfg_next.width  = pwdata[12:0];
                REG_SURFACE_HEIGHT: cfg_next.height = pwdata[12:0];
                REG_BYTES_PER_PIX:  cfg_next.bpp    = pwdata[2:0];
                REG_ROW_PITCH:      cfg_next.pitch  = pwdata[15:0];
                REG_BASE_ADDRESS:   cfg_next.base   = pwdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SURFACE_WIDTH:  prdata = {19'd0, cfg_reg.width};
            REG_SURFACE_HEIGHT: prdata = {19'd0, cfg_reg.height};
            REG_BYTES_PER_PIX:  prdata = {29'd0, cfg_reg.bpp};
            REG_ROW_PITCH:      prdata = {16'd0, cfg_reg.pitch};
            REG_BASE_ADDRESS:   prdata = cfg_reg.base;
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= 13'd4096;
            cfg_reg.height <= 13'd4096;
            cfg_reg.bpp    <= 3'd4;
            cfg_reg.pitch  <= 16'd16384;
            cfg_reg.base   <= 32'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lrc_front #(.COORD_BITS(COORD_BITS)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .line_color (line_color),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_cmd      (q_cmd),
        .q_x0       (q_x0),
        .q_y0       (q_y0),
        .q_x1       (q_x1),
        .q_y1       (q_y1),
        .q_adx      (q_adx),
        .q_ady      (q_ady),
        .q_color    (q_color)
    );

    lrc_stepper #(.COORD_BITS(COORD_BITS)) u_stepper
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .q_x0      (q_x0),
        .q_y0      (q_y0),
        .q_x1      (q_x1),
        .q_y1      (q_y1),
        .q_adx     (q_adx),
        .q_ady     (q_ady),
        .q_color   (q_color),
        .pix_ready (pix_ready),
        .pix_valid (pix_valid),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .pix_last  (pix_last),
        .pix_color (pix_color)
    );

    lrc_pixel #(.COORD_BITS(COORD_BITS)) u_pixel
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pix_valid     (pix_valid),
        .pix_ready     (pix_ready),
        .pix_x         (pix_x),
        .pix_y         (pix_y),
        .pix_last      (pix_last),
        .pix_color     (pix_color),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .visible       (visible),
        .write_address (write_address),
        .pixel_value   (pixel_value),
        .last          (last)
    );

endmodule

// ===== rtl/lrc_checker.sv =====
// Port-level checks of the clipped line rasterizer and their bind to the top level.
`include "assert_macros.svh"

module lrc_checker #(
    parameter int COORD_BITS = 12
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         pready,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [COORD_BITS-1:0] pixel_x,
    input logic signed [COORD_BITS-1:0] pixel_y,
    input logic                         visible,
    input logic [31:0]                  write_address,
    input logic [31:0]                  pixel_value,
    input logic                         last
);

    logic [2*COORD_BITS+65:0] out_payload;

    assign out_payload = {pixel_x, pixel_y, visible, write_address, pixel_value, last};

    // A stalled pixel keeps its whole payload until it is taken.
    `LRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

    // A pixel inside the clip window never has a negative coordinate.
    `LRC_ASSERT_NOW(a_vis_nonneg, out_valid && visible, (pixel_x >= 0) && (pixel_y >= 0))

    // The configuration port never inserts wait states.
    `LRC_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind line_rasterizer_clipped_top lrc_checker #(.COORD_BITS(COORD_BITS)) u_lrc_checker (.*);

// ===== tb/line_rasterizer_clipped_top_test.sv =====
// Self-checking testbench for the clipped line rasterizer: line traffic, stalls and surface setups.
module line_rasterizer_clipped_top_test;
    import lrc_pkg::*;

    localparam int COORD_W        = 12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_QUOTA    = 170;

    typedef struct {
        logic                      func;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic [31:0]               color;
    } draw_cmd_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      visible;
        logic [31:0]               addr;
        logic [31:0]               value;
        logic                      last;
    } pixel_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [4:0]                paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      func = 1'b0;
    logic signed [COORD_W-1:0] start_x = '0;
    logic signed [COORD_W-1:0] start_y = '0;
    logic signed [COORD_W-1:0] end_x = '0;
    logic signed [COORD_W-1:0] end_y = '0;
    logic [31:0]               line_color = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic                      visible;
    logic [31:0]               write_address;
    logic [31:0]               pixel_value;
    logic                      last;

    // Surface setup as the block should hold it.
    logic [12:0] cfg_width = 13'd4096;
    logic [12:0] cfg_height = 13'd4096;
    logic [2:0]  cfg_bpp = 3'd4;
    logic [15:0] cfg_pitch = 16'd16384;
    logic [31:0] cfg_base = 32'd0;

    // Line stepper state.
    logic signed [COORD_W-1:0] pen_x = '0;
    logic signed [COORD_W-1:0] pen_y = '0;
    logic signed [COORD_W-1:0] goal_x = '0;
    logic signed [COORD_W-1:0] goal_y = '0;
    logic                      dir_neg_x = 1'b0;
    logic                      dir_neg_y = 1'b0;
    logic [12:0]               span_x = '0;
    logic [12:0]               span_y = '0;
    logic                      along_x = 1'b0;
    logic signed [14:0]        slope_err = '0;
    logic [31:0]               ink = '0;
    logic                      drawing = 1'b0;

    draw_cmd_t pending_cmds[$];
    pixel_t    pixels_due[$];
    draw_cmd_t drive_cmd;
    pixel_t    next_pixel;
    pixel_t    want;
    bit        took;
    int        send_gap = 0;
    int        send_calm = 0;
    int        stall_left = 0;
    int        stall_calm = 0;
    int        quiet_cycles = 0;
    int        mismatches = 0;

    line_rasterizer_clipped_top #(.COORD_BITS(COORD_W)) uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .func(func),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .line_color(line_color),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .visible(visible),
        .write_address(write_address), .pixel_value(pixel_value), .last(last)
    );

    always #10 clk = ~clk;

    function automatic bit line_done();
        return along_x ? (pen_x == goal_x) : (pen_y == goal_y);
    endfunction

    function automatic pixel_t make_pixel(bit is_last);
        pixel_t      p;
        int          px;
        int          py;
        logic [31:0] ux;
        logic [31:0] uy;
        px = int'(pen_x);
        py = int'(pen_y);
        ux = px;
        uy = py;
        p.x = pen_x;
        p.y = pen_y;
        // The clip window stops one short of the surface edge on both axes.
        p.visible = px >= 0 && px < int'(cfg_width) - 1 && py >= 0 && py < int'(cfg_height) - 1;
        p.addr = cfg_base + ux * cfg_bpp + uy * cfg_pitch;
        p.value = ink;
        p.last = is_last;
        return p;
    endfunction

    function automatic bit rasterize_cmd(input draw_cmd_t c, output pixel_t p);
        int dx;
        int dy;
        int err;
        if (c.func == FUNC_START)
        begin
            pen_x = c.sx;
            pen_y = c.sy;
            goal_x = c.ex;
            goal_y = c.ey;
            ink = c.color;
            dx = int'(goal_x) - int'(pen_x);
            dy = int'(goal_y) - int'(pen_y);
            dir_neg_x = dx < 0;
            dir_neg_y = dy < 0;
            span_x = 13'(dir_neg_x ? -dx : dx);
            span_y = 13'(dir_neg_y ? -dy : dy);
            along_x = span_y < span_x;
            slope_err = '0;
            drawing = !line_done();
            p = make_pixel(!drawing);
            return 1'b1;
        end
        if (!drawing)
            return 1'b0;
        err = int'(slope_err);
        if (along_x)
        begin
            pen_x = COORD_W'(dir_neg_x ? pen_x - 1 : pen_x + 1);
            err += 2 * int'(span_y);
            if (err > int'(span_x))
            begin
                pen_y = COORD_W'(dir_neg_y ? pen_y - 1 : pen_y + 1);
                err -= 2 * int'(span_x);
            end
        end
        else
        begin
            pen_y = COORD_W'(dir_neg_y ? pen_y - 1 : pen_y + 1);
            err += 2 * int'(span_x);
            if (err > int'(span_y))
            begin
                pen_x = COORD_W'(dir_neg_x ? pen_x - 1 : pen_x + 1);
                err -= 2 * int'(span_y);
            end
        end
        slope_err = 15'(err);
        drawing = !line_done();
        p = make_pixel(!drawing);
        return 1'b1;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(40, 200);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    function automatic int rand_coord();
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        return v;
    endfunction

    function automatic int near_coord(int dim);
        int s;
        s = (dim > 200) ? 200 : dim;
        return clamp_coord(int'($urandom_range(0, s + 16)) - 8);
    endfunction

    task automatic push_junk(logic f);
        draw_cmd_t c;
        c.func = f;
        c.sx = COORD_W'($urandom);
        c.sy = COORD_W'($urandom);
        c.ex = COORD_W'($urandom);
        c.ey = COORD_W'($urandom);
        c.color = $urandom;
        pending_cmds.push_back(c);
    endtask

    task automatic push_line(int sx, int sy, int ex, int ey, logic [31:0] color, int n_adv);
        draw_cmd_t c;
        c.func = FUNC_START;
        c.sx = COORD_W'(sx);
        c.sy = COORD_W'(sy);
        c.ex = COORD_W'(ex);
        c.ey = COORD_W'(ey);
        c.color = color;
        pending_cmds.push_back(c);
        repeat (n_adv) push_junk(FUNC_ADVANCE);
    endtask

    task automatic random_lines(int quota);
        int   counted;
        int   r;
        int   q;
        int   reach;
        int   sx;
        int   sy;
        int   ex;
        int   ey;
        int   len;
        int   n;
        logic f;
        counted = 0;
        while (counted < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                f = 1'($urandom_range(0, 1));
                push_junk(f);
                if (f == FUNC_START)
                    counted++;
            end
            else
            begin
                if (r < 70)
                begin
                    sx = near_coord(int'(cfg_width));
                    sy = near_coord(int'(cfg_height));
                end
                else
                begin
                    sx = rand_coord();
                    sy = rand_coord();
                end
                reach = (r >= 85) ? 150 : 12;
                ex = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
                ey = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
                if (r >= 95)
                begin
                    ex = rand_coord();
                    ey = rand_coord();
                end
                len = (ex > sx) ? ex - sx : sx - ex;
                if (((ey > sy) ? ey - sy : sy - ey) > len)
                    len = (ey > sy) ? ey - sy : sy - ey;
                q = $urandom_range(0, 99);
                if (q < 75)
                    n = len;
                else if (q < 88)
                    n = $urandom_range(0, len);
                else
                    n = len + $urandom_range(1, 3);
                // Very long lines are cut short by the next start.
                if (r >= 95 && n > 24)
                    n = $urandom_range(0, 24);
                push_line(sx, sy, ex, ey, $urandom, n);
                counted += 1 + ((n < len) ? n : len);
            end
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SURFACE_WIDTH:  cfg_width = data[12:0];
            REG_SURFACE_HEIGHT: cfg_height = data[12:0];
            REG_BYTES_PER_PIX:  cfg_bpp = data[2:0];
            REG_ROW_PITCH:      cfg_pitch = data[15:0];
            REG_BASE_ADDRESS:   cfg_base = data;
            default: ;
        endcase
    endtask

    task automatic program_surface(logic [31:0] w, logic [31:0] h, logic [31:0] bpp,
                                   logic [31:0] pitch, logic [31:0] base);
        write_reg(REG_SURFACE_WIDTH, w);
        write_reg(REG_SURFACE_HEIGHT, h);
        write_reg(REG_BYTES_PER_PIX, bpp);
        write_reg(REG_ROW_PITCH, pitch);
        write_reg(REG_BASE_ADDRESS, base);
    endtask

    // Sampled on the falling edge so that the clocked blocks have settled.
    task automatic drain_and_settle(int settle);
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || pixels_due.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                if (rasterize_cmd(drive_cmd, next_pixel))
                    pixels_due.push_back(next_pixel);
            end
            if (!in_valid || took)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    drive_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    func <= drive_cmd.func;
                    start_x <= drive_cmd.sx;
                    start_y <= drive_cmd.sy;
                    end_x <= drive_cmd.ex;
                    end_y <= drive_cmd.ey;
                    line_color <= drive_cmd.color;
                    send_gap = idle_len(send_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pixels_due.size() == 0)
                begin
                    $error("unexpected pixel at x=%0d y=%0d", pixel_x, pixel_y);
                    mismatches++;
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (pixel_x !== want.x)
                    begin
                        $error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
                        mismatches++;
                    end
                    if (pixel_y !== want.y)
                    begin
                        $error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
                        mismatches++;
                    end
                    if (visible !== want.visible)
                    begin
                        $error("visible: expected %0b, got %0b", want.visible, visible);
                        mismatches++;
                    end
                    if (write_address !== want.addr)
                    begin
                        $error("write_address: expected %h, got %h", want.addr, write_address);
                        mismatches++;
                    end
                    if (pixel_value !== want.value)
                    begin
                        $error("pixel_value: expected %h, got %h", want.value, pixel_value);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = idle_len(stall_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset surface: origin, both major axes, negative steps, equal deltas,
        // an advance with no line running, extreme corners and a restart mid-line.
        push_line(0, 0, 0, 0, 32'h0000_0000, 0);
        push_line(0, 0, 3, 0, 32'hA5A5_5A5A, 3);
        push_line(2, 2, 0, -2, 32'h1234_5678, 4);
        push_line(-1, -1, 1, 1, 32'hFFFF_0000, 2);
        push_junk(FUNC_ADVANCE);
        push_line(-2048, -2048, 2047, 2047, 32'hFFFF_FFFF, 2);
        push_line(2047, 2047, -2048, 2047, 32'h0000_0000, 1);
        push_line(2047, -2048, 2047, -2048, 32'h5555_5555, 0);
        push_line(10, 10, 14, 11, 32'hC3C3_3C3C, 4);
        drain_and_settle(10);

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: program_surface(64, 48, 4, 256, 32'h1000_0000);
                1: program_surface(0, 1, 0, 65535, 32'hFFFF_FFFF);
                2: program_surface(1, 0, 7, 0, 0);
                3: program_surface(4096, 4096, 4, 16384, 0);
                4: program_surface(32'hFFFF_FFFF, 4097, 3, 1, 32'h8000_0000);
                5: program_surface($urandom_range(2, 300), $urandom_range(2, 300),
                                   $urandom_range(0, 4), $urandom, $urandom);
                default: program_surface($urandom_range(2, 40), $urandom_range(2, 40),
                                         $urandom_range(1, 4), $urandom_range(0, 200),
                                         $urandom);
            endcase
            random_lines(PHASE_QUOTA);
            drain_and_settle(10);
        end

        drain_and_settle(100);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lrc_pkg.sv
rtl/lrc_front.sv
rtl/lrc_stepper.sv
rtl/lrc_pixel.sv
rtl/line_rasterizer_clipped_top.sv
rtl/lrc_checker.sv
tb/line_rasterizer_clipped_top_test.sv
